>>> rtl/dvft_pkg.sv
`timescale 1ns / 1ps

package dvft_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COUNT_BITS    = 16;
  localparam int VALUE_BITS    = 32;

  // list element travelling down the chain
  typedef struct packed {
    logic                  valid;
    logic                  done;   // already counted or placed by an earlier cell
    logic [VALUE_BITS-1:0] value;
  } tok_t;

  // contents of one table entry
  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
  } ent_t;

endpackage

>>> rtl/dvft_cell.sv
`timescale 1ns / 1ps

module dvft_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  dvft_pkg::tok_t tok_in,
  output dvft_pkg::tok_t tok_out,
  input  logic           shift_en,
  input  dvft_pkg::ent_t ent_in,
  output dvft_pkg::ent_t ent_out
);
  import dvft_pkg::*;

  tok_t tok_r;
  ent_t ent_r;
  logic live;
  logic hit;
  logic claim;
  logic cnt_max;

  assign live    = tok_in.valid && !tok_in.done;
  assign hit     = live && ent_r.valid && (ent_r.value == tok_in.value);
  assign claim   = live && !ent_r.valid;
  assign cnt_max = (ent_r.count == {COUNT_BITS{1'b1}});

  always_ff @(posedge clk) begin
    // control bits
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
      ent_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_in.valid;
      if (shift_en) begin
        ent_r.valid <= ent_in.valid;
      end else if (claim) begin
        ent_r.valid <= 1'b1;
      end
    end
    // payload
    tok_r.done  <= tok_in.done | hit | claim;
    tok_r.value <= tok_in.value;
    if (shift_en) begin
      ent_r.value <= ent_in.value;
      ent_r.count <= ent_in.count;
    end else if (claim) begin
      ent_r.value <= tok_in.value;
      ent_r.count <= COUNT_BITS'(1);
    end else if (hit && !cnt_max) begin
      ent_r.count <= ent_r.count + COUNT_BITS'(1);
    end
  end

  assign tok_out = tok_r;
  assign ent_out = ent_r;

endmodule

>>> rtl/distinct_value_frequency_table.sv
`timescale 1ns / 1ps

// Distinct value frequency table. Each input transaction carries one signed
// 32-bit list element; in_end_of_list marks the final element. Elements walk
// down a chain of TABLE_ENTRIES cells, one cell per cycle; the first cell that
// holds the same value bumps its count (saturating at all ones), and the first
// empty cell takes a new value with count 1, so entries sit in order of first
// appearance. An element that leaves the chain unplaced sets the overflow flag.
// While a list streams in, one element is taken every cycle. After the final
// element is taken, in_stall stays high while the chain drains. The table is
// then read out from the head cell, one result transaction per cycle unless
// out_stall holds it, with every cell shifting one place toward the head on
// each read. out_final_entry marks the last result; out_table_overflow is the
// same on every result of the list. Reading out the last result empties the
// table and clears the flag, and the next list is accepted from the following
// cycle.
module distinct_value_frequency_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [dvft_pkg::VALUE_BITS-1:0] in_value,
  input  logic                              in_end_of_list,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [dvft_pkg::VALUE_BITS-1:0] out_distinct_value,
  output logic [dvft_pkg::COUNT_BITS-1:0]   out_occurrences,
  output logic                              out_final_entry,
  output logic                              out_table_overflow
);
  import dvft_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_ABSORB = 2'd0;  // taking list elements
  localparam logic [1:0] ST_FLUSH  = 2'd1;  // waiting for the chain to empty
  localparam logic [1:0] ST_DRAIN  = 2'd2;  // reading out the table

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       overflow_r;
  logic       overflow_nxt;

  // tok[i] enters cell i, ent[i] is the contents of cell i
  tok_t tok [0:TABLE_ENTRIES];
  ent_t ent [0:TABLE_ENTRIES];

  logic in_accept;
  logic out_accept;
  logic shift_en;
  logic any_tok;

  assign in_stall   = (state_r != ST_ABSORB);
  assign in_accept  = in_valid && !in_stall;
  assign out_valid  = (state_r == ST_DRAIN) && ent[0].valid;
  assign out_accept = out_valid && !out_stall;
  assign shift_en   = out_accept;

  // new element enters at the head of the chain
  assign tok[0].valid = in_accept;
  assign tok[0].done  = 1'b0;
  assign tok[0].value = in_value;

  // nothing follows the last cell when shifting toward the head
  assign ent[TABLE_ENTRIES] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      dvft_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_in   (tok[gi]),
        .tok_out  (tok[gi+1]),
        .shift_en (shift_en),
        .ent_in   (ent[gi+1]),
        .ent_out  (ent[gi])
      );
    end
  endgenerate

  // any element still walking the chain
  always_comb begin
    any_tok = 1'b0;
    for (int k = 1; k <= TABLE_ENTRIES; k++) begin
      any_tok = any_tok | tok[k].valid;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    overflow_nxt = overflow_r;
    // element fell off the end without a home
    if (tok[TABLE_ENTRIES].valid && !tok[TABLE_ENTRIES].done) begin
      overflow_nxt = 1'b1;
    end
    case (state_r)
      ST_ABSORB: begin
        if (in_accept && in_end_of_list) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!any_tok) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_accept && out_final_entry) begin
          state_nxt    = ST_ABSORB;
          overflow_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_ABSORB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_ABSORB;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // results come straight from the head cell
  assign out_distinct_value = signed'(ent[0].value);
  assign out_occurrences    = ent[0].count;
  assign out_final_entry    = !ent[1].valid;
  assign out_table_overflow = overflow_r;

  // results only while reading out
  a_out_only_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_DRAIN))
    else $error("result offered outside read-out");

  // chain is empty before read-out starts
  a_drain_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> !any_tok)
    else $error("element still in chain during read-out");

  // read-out never runs on an empty table
  a_drain_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> ent[0].valid)
    else $error("read-out with empty head cell");

  // last result empties table and clears the flag
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_accept && out_final_entry) |=>
      (state_r == ST_ABSORB) && !overflow_r && !ent[0].valid)
    else $error("table not cleared after last result");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  import dvft_pkg::*;

  // watchdog limit: cycles in a row with no transaction on either side
  localparam int STALL_LIMIT = 1000;
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

  // one result transaction as the block should produce it
  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0]        count;
    logic                         last;
    logic                         overflow;
  } tally_entry_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [VALUE_BITS-1:0] in_value;
  logic                         in_end_of_list;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [VALUE_BITS-1:0] out_distinct_value;
  logic [COUNT_BITS-1:0]        out_occurrences;
  logic                         out_final_entry;
  logic                         out_table_overflow;

  distinct_value_frequency_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .in_end_of_list     (in_end_of_list),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_distinct_value (out_distinct_value),
    .out_occurrences    (out_occurrences),
    .out_final_entry    (out_final_entry),
    .out_table_overflow (out_table_overflow)
  );

  // shadow copy of the frequency table
  logic [VALUE_BITS-1:0] shadow_value [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0] shadow_count [TABLE_ENTRIES];
  int unsigned           shadow_used;
  bit                    shadow_overflow;

  // results still owed by the block, oldest first
  tally_entry_t awaited_entries[$];
  tally_entry_t want;

  int error_count;
  int items_sent;
  int idle_cycles;
  bit idling_on;

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // fold one element into the shadow table; on the final element queue the
  // whole table as awaited results and start over
  function automatic void tally_element(input logic [VALUE_BITS-1:0] v, input logic eol);
    bit           hit;
    tally_entry_t e;
    hit = 1'b0;
    for (int k = 0; k < shadow_used; k++) begin
      if (!hit && shadow_value[k] == v) begin
        hit = 1'b1;
        // count saturation: a full count stays put
        if (shadow_count[k] != COUNT_TOP) shadow_count[k]++;
      end
    end
    if (!hit) begin
      if (shadow_used < TABLE_ENTRIES) begin
        shadow_value[shadow_used] = v;
        shadow_count[shadow_used] = COUNT_BITS'(1);
        shadow_used++;
      end else begin
        // table full: the new value is dropped
        shadow_overflow = 1'b1;
      end
    end
    if (eol) begin
      for (int k = 0; k < shadow_used; k++) begin
        e.value    = shadow_value[k];
        e.count    = shadow_count[k];
        e.last     = (k + 1 == shadow_used);
        e.overflow = shadow_overflow;
        awaited_entries.push_back(e);
      end
      shadow_used     = 0;
      shadow_overflow = 1'b0;
    end
  endfunction

  // monitor: predict on every accepted element, check every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tally_element(in_value, in_end_of_list);
      if (out_valid && !out_stall) begin
        if (awaited_entries.size() == 0) begin
          $error("unexpected result: distinct_value %0d occurrences %0d",
                 out_distinct_value, out_occurrences);
          error_count++;
        end else begin
          want = awaited_entries.pop_front();
          if (out_distinct_value !== want.value) begin
            $error("distinct_value: expected %0d, got %0d", want.value, out_distinct_value);
            error_count++;
          end
          if (out_occurrences !== want.count) begin
            $error("occurrences: expected %0d, got %0d", want.count, out_occurrences);
            error_count++;
          end
          if (out_final_entry !== want.last) begin
            $error("final_entry: expected %0d, got %0d", want.last, out_final_entry);
            error_count++;
          end
          if (out_table_overflow !== want.overflow) begin
            $error("table_overflow: expected %0d, got %0d", want.overflow,
                   out_table_overflow);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog: ends the run when the block goes quiet for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("FAIL distinct_value_frequency_table");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side back-pressure in random bursts, with calm stretches
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        // a run of cycles with no back-pressure at all
        repeat ($urandom_range(8, 30)) @(posedge clk);
      end
    end
  end

  // send one element; valid stays high afterward unless a gap follows
  task automatic send_element(input logic signed [VALUE_BITS-1:0] v, input logic eol);
    int gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= v;
    in_end_of_list <= eol;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // extremes of the value field, repeats and one-element lists
  task automatic test_extremes;
    send_element(32'sh8000_0000, 1'b1);
    send_element(32'sh7fff_ffff, 1'b1);
    send_element(32'sh7fff_ffff, 1'b0);
    send_element(32'sh8000_0000, 1'b0);
    send_element(32'sh0000_0000, 1'b0);
    send_element(32'shffff_ffff, 1'b0);
    send_element(32'sh8000_0000, 1'b0);
    send_element(32'sh0000_0001, 1'b0);
    send_element(32'shffff_ffff, 1'b1);
  endtask

  // a list that fills every entry, then repeats a value and overflows
  task automatic test_table_full;
    logic [VALUE_BITS-1:0] base;
    base = $urandom;
    for (int i = 0; i < TABLE_ENTRIES; i++) send_element(base ^ i, 1'b0);
    send_element(base, 1'b0);
    // dropped values, the final element among them
    send_element(base ^ 32'h8000_0000, 1'b0);
    send_element(base ^ 32'h0000_8000, 1'b1);
  endtask

  // one random list drawn from a small pool so values repeat
  task automatic send_random_list(input int len, input int pool_size);
    logic [VALUE_BITS-1:0] pool [$];
    logic [VALUE_BITS-1:0] v;
    int                    flavor;
    flavor = $urandom_range(0, 2);
    for (int i = 0; i < pool_size; i++) begin
      case (flavor)
        0:       pool.push_back($urandom);
        1:       pool.push_back($urandom_range(0, 15) - 8);
        default: pool.push_back($urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                      : 32'h7fff_ffff - $urandom_range(0, 3));
      endcase
    end
    for (int i = 0; i < len; i++) begin
      v = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
      send_element(v, i == len - 1);
    end
  endtask

  // short random lists with repeating values
  task automatic test_random_lists;
    int goal;
    goal = items_sent + 40;
    while (items_sent < goal) begin
      send_random_list($urandom_range(1, 12), $urandom_range(1, 8));
    end
  endtask

  // closing lists at full rate on both sides
  task automatic test_back_to_back;
    idling_on = 1'b0;
    repeat (3) send_random_list($urandom_range(1, 8), $urandom_range(1, 6));
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_value       <= '0;
    in_end_of_list <= 1'b0;
    error_count     = 0;
    items_sent      = 0;
    idle_cycles     = 0;
    idling_on       = 1'b1;
    shadow_used     = 0;
    shadow_overflow = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_table_full();
    test_random_lists();
    test_back_to_back();

    in_valid <= 1'b0;
    // drain: wait for every owed result, then idle on before the verdict
    while (awaited_entries.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 16) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS distinct_value_frequency_table");
    end else begin
      $display("FAIL distinct_value_frequency_table");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/dvft_pkg.sv
rtl/dvft_cell.sv
rtl/distinct_value_frequency_table.sv
tb/sv/tb.sv
